// File: rtl/core/gsbc_pkg.sv
package gsbc_pkg;

    // window geometry and sample format
    localparam int WINDOW_DEPTH = 50;
    localparam int SAMPLE_WIDTH = 16;

    // fixed field widths
    localparam int IN_W        = 16;
    localparam int OFFSET_W    = 20;
    localparam int COUNT_W     = 16;
    localparam int TEMP_W      = 16;
    localparam int SPREAD_CFG_W = 16;
    localparam int MEAN_CFG_W  = 15;
    localparam int LIMIT_CFG_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 8;

    // derived widths
    localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
    localparam int DEPTH_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int MAG_W    = SAMPLE_WIDTH - 1 + DEPTH_W;
    localparam int SUM_W    = MAG_W + 1;
    localparam int DIFF_W   = SAMPLE_WIDTH + 1;
    localparam int SQR_W    = 2 * (SAMPLE_WIDTH - 1) + 1;
    localparam int QSUM_W   = 2 * (SAMPLE_WIDTH - 1) + DEPTH_W;
    localparam int NQ_W     = QSUM_W + DEPTH_W;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int SPREAD_W = NQ_W + 2;
    localparam int ABSM_W   = MAG_W + 2;
    localparam int SPREAD_LIM_W = SPREAD_CFG_W + 2 * DEPTH_W;
    localparam int MEAN_LIM_W   = MEAN_CFG_W + DEPTH_W;
    localparam int SCMP_W = (SPREAD_W > SPREAD_LIM_W) ? SPREAD_W : SPREAD_LIM_W;
    localparam int MCMP_W = (ABSM_W > MEAN_LIM_W) ? ABSM_W : MEAN_LIM_W;

    // rounded mean by reciprocal multiply: quo = (16*|s| + N/2) / N, exact for NUM_W bits
    localparam int NUM_W     = MAG_W + 5;
    localparam int DIV_SHIFT = NUM_W + SLOT_W;
    localparam int RECIP_W   = NUM_W + 2;
    localparam int QUO_W     = SAMPLE_WIDTH + 4;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT)
        + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
    localparam logic [NUM_W-1:0] HALF_N = NUM_W'(WINDOW_DEPTH / 2);

    // offset saturation
    localparam int SAT_W = ((QUO_W > OFFSET_W) ? QUO_W : OFFSET_W) + 1;
    localparam longint unsigned OFF_NEG_MAX = 64'd1 << (OFFSET_W - 1);
    localparam longint unsigned OFF_POS_MAX = OFF_NEG_MAX - 64'd1;

    // reset values of the configuration registers
    localparam logic signed [TEMP_W-1:0]  TEMP_THR_RST    = TEMP_W'(8192);
    localparam logic [SPREAD_LIM_W-1:0]   SPREAD_LIM_RST  =
        SPREAD_LIM_W'(17 * WINDOW_DEPTH * WINDOW_DEPTH);
    localparam logic [MEAN_LIM_W-1:0]     MEAN_LIM_RST    = MEAN_LIM_W'(98 * WINDOW_DEPTH);
    localparam logic [LIMIT_CFG_W-1:0]    STILL_LIMIT_RST = LIMIT_CFG_W'(200);
    localparam logic [COUNT_W-1:0]        COUNT_MAX       = '1;

    // result queue, deep enough for every item in flight
    localparam int OUTQ_DEPTH = 16;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CREDIT_W   = OUTQ_PTR_W + 1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TEMP_THR    = 8'd0,
        CFG_SPREAD_THR  = 8'd1,
        CFG_MEAN_THR    = 8'd2,
        CFG_STILL_LIMIT = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [SPREAD_LIM_W-1:0] spread_lim;
        logic [MEAN_LIM_W-1:0]   mean_lim;
    } t_limits;

    typedef struct packed {
        logic                       valid;
        logic                       hot;
        logic [2:0][SUM_W-1:0]      sum;
        logic [2:0][QSUM_W-1:0]     sq;
    } t_window_stat;

    typedef struct packed {
        logic                   valid;
        logic                   hot;
        logic                   still;
        logic [2:0]             neg;
        logic [2:0][QUO_W-1:0]  quo;
    } t_verdict;

    typedef struct packed {
        logic                       still_flag;
        logic                       calibrated;
        logic [2:0][OFFSET_W-1:0]   offset;
        logic [COUNT_W-1:0]         still_count;
    } t_result;

    // clamp a rounded mean magnitude and apply its sign
    function automatic logic [OFFSET_W-1:0] sat_offset(input logic [QUO_W-1:0] quo,
                                                      input logic neg);
        logic [SAT_W-1:0] mag;
        logic [SAT_W-1:0] lim;
        mag = SAT_W'(quo);
        lim = neg ? SAT_W'(OFF_NEG_MAX) : SAT_W'(OFF_POS_MAX);
        if (mag > lim) begin
            mag = lim;
        end
        return neg ? OFFSET_W'(~mag + SAT_W'(1)) : OFFSET_W'(mag);
    endfunction

endpackage

// File: rtl/core/gsbc_ram.sv
module gsbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/gsbc_window.sv
module gsbc_window
    import gsbc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_hot,
    input  logic [2:0][IN_W-1:0]    i_gyro,
    output t_window_stat            o_stat
);

    logic [SLOT_W-1:0]                  r_slot;
    logic                               r_full;

    logic                               r_p1_valid;
    logic                               r_p1_hot;
    logic                               r_p1_full;
    logic [SLOT_W-1:0]                  r_p1_slot;
    logic [2:0][SAMPLE_WIDTH-1:0]       r_p1_smp;

    logic                               r_p2_valid;
    logic                               r_p2_hot;
    logic [2:0][DIFF_W-1:0]             r_p2_diff;
    logic [2:0][SQR_W-1:0]              r_p2_sq_new;
    logic [2:0][SQR_W-1:0]              r_p2_sq_old;

    logic                               r_v3;
    logic                               r_hot3;
    logic [2:0][SUM_W-1:0]              r_sum;
    logic [2:0][QSUM_W-1:0]             r_sq;

    logic [2:0][SAMPLE_WIDTH-1:0]       smp_in;
    logic [2:0][SAMPLE_WIDTH-1:0]       rd_smp;
    logic [2:0][SAMPLE_WIDTH-1:0]       old_smp;
    logic signed [2*SAMPLE_WIDTH-1:0]   sq_new_full [3];
    logic signed [2*SAMPLE_WIDTH-1:0]   sq_old_full [3];
    logic [2:0][DIFF_W-1:0]             n_diff;
    logic [2:0][SQR_W-1:0]              n_sq_new;
    logic [2:0][SQR_W-1:0]              n_sq_old;
    logic                               slot_wrap;

    // wrap raw words to the sample width
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            smp_in[a] = SAMPLE_WIDTH'($signed(i_gyro[a]));
        end
    end

    assign slot_wrap = (r_slot == SLOT_W'(WINDOW_DEPTH - 1));

    // write slot and first-pass tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
        end else if (i_accept) begin
            r_slot <= slot_wrap ? '0 : r_slot + SLOT_W'(1);
            if (slot_wrap) begin
                r_full <= 1'b1;
            end
        end
    end

    // window memory: oldest sample read on accept, new sample written in the next cycle
    gsbc_ram #(
        .WIDTH (3 * SAMPLE_WIDTH),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_p1_valid),
        .i_wr_addr (r_p1_slot),
        .i_wr_data (r_p1_smp),
        .i_rd_en   (i_accept),
        .i_rd_addr (r_slot),
        .o_rd_data (rd_smp)
    );

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_accept;
        end
        r_p1_hot  <= i_hot;
        r_p1_full <= r_full;
        r_p1_slot <= r_slot;
        r_p1_smp  <= smp_in;
    end

    // entries not yet written on the first pass read as zero
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            old_smp[a]     = r_p1_full ? rd_smp[a] : '0;
            n_diff[a]      = DIFF_W'($signed(r_p1_smp[a])) - DIFF_W'($signed(old_smp[a]));
            sq_new_full[a] = $signed(r_p1_smp[a]) * $signed(r_p1_smp[a]);
            sq_old_full[a] = $signed(old_smp[a]) * $signed(old_smp[a]);
            n_sq_new[a]    = sq_new_full[a][SQR_W-1:0];
            n_sq_old[a]    = sq_old_full[a][SQR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
        r_p2_hot    <= r_p1_hot;
        r_p2_diff   <= n_diff;
        r_p2_sq_new <= n_sq_new;
        r_p2_sq_old <= n_sq_old;
    end

    // running sums and sums of squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3  <= 1'b0;
            r_sum <= '0;
            r_sq  <= '0;
        end else begin
            r_v3 <= r_p2_valid;
            if (r_p2_valid) begin
                for (int a = 0; a < 3; a++) begin
                    r_sum[a] <= r_sum[a] + SUM_W'($signed(r_p2_diff[a]));
                    r_sq[a]  <= r_sq[a] + QSUM_W'(r_p2_sq_new[a]) - QSUM_W'(r_p2_sq_old[a]);
                end
            end
        end
        r_hot3 <= r_p2_hot;
    end

    assign o_stat = '{valid: r_v3, hot: r_hot3, sum: r_sum, sq: r_sq};

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(WINDOW_DEPTH))
        else $error("write slot out of window");
`endif

endmodule

// File: rtl/core/gsbc_stats.sv
module gsbc_stats
    import gsbc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_window_stat    i_stat,
    input  t_limits         i_lim,
    output t_verdict        o_verdict
);

    logic                       r_v4;
    logic                       r_hot4;
    logic [2:0]                 r_neg4;
    logic [2:0][MAG_W-1:0]      r_mag;
    logic [2:0][PROD_W-1:0]     r_mm;
    logic [2:0][NQ_W-1:0]       r_nq;
    logic [2:0][NUM_W-1:0]      r_num;

    logic                       r_v5;
    logic                       r_hot5;
    logic [2:0]                 r_neg5;
    logic [2:0][NQ_W-1:0]       r_var;
    logic [ABSM_W-1:0]          r_absm;
    logic [2:0][QUO_W-1:0]      r_quo5;

    logic                       r_v6;
    logic                       r_hot6;
    logic                       r_still;
    logic [2:0]                 r_neg6;
    logic [2:0][QUO_W-1:0]      r_quo6;

    logic [2:0]                 n_neg;
    logic [2:0][MAG_W-1:0]      n_mag;
    logic [2:0][PROD_W-1:0]     n_mm;
    logic [2:0][NQ_W-1:0]       n_nq;
    logic [2:0][NUM_W-1:0]      n_num;
    logic [2:0][NQ_W-1:0]       n_var;
    logic [ABSM_W-1:0]          n_absm;
    logic [NUM_W+RECIP_W-1:0]   quo_prod [3];
    logic [2:0][QUO_W-1:0]      n_quo;
    logic [SPREAD_W-1:0]        spread;
    logic                       n_still;

    // magnitudes, squares of sums, scaled square sums, rounding numerators
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_neg[a] = i_stat.sum[a][SUM_W-1];
            n_mag[a] = MAG_W'(n_neg[a] ? (~i_stat.sum[a] + SUM_W'(1)) : i_stat.sum[a]);
            n_mm[a]  = n_mag[a] * n_mag[a];
            n_nq[a]  = NQ_W'(i_stat.sq[a]) * NQ_W'(WINDOW_DEPTH);
            n_num[a] = {NUM_W'(n_mag[a]) << 4} + HALF_N;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_stat.valid;
        end
        r_hot4 <= i_stat.hot;
        r_neg4 <= n_neg;
        r_mag  <= n_mag;
        r_mm   <= n_mm;
        r_nq   <= n_nq;
        r_num  <= n_num;
    end

    // per-axis variance terms, mean magnitude sum, rounded means
    always_comb begin
        n_absm = '0;
        for (int a = 0; a < 3; a++) begin
            n_var[a]    = r_nq[a] - NQ_W'(r_mm[a]);
            n_absm      = n_absm + ABSM_W'(r_mag[a]);
            quo_prod[a] = r_num[a] * RECIP;
            n_quo[a]    = quo_prod[a][DIV_SHIFT +: QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_hot5 <= r_hot4;
        r_neg5 <= r_neg4;
        r_var  <= n_var;
        r_absm <= n_absm;
        r_quo5 <= n_quo;
    end

    // stillness test against the pre-scaled limits
    always_comb begin
        spread  = SPREAD_W'(r_var[0]) + SPREAD_W'(r_var[1]) + SPREAD_W'(r_var[2]);
        n_still = (SCMP_W'(spread) < SCMP_W'(i_lim.spread_lim))
               && (MCMP_W'(r_absm) < MCMP_W'(i_lim.mean_lim));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_hot6  <= r_hot5;
        r_still <= n_still;
        r_neg6  <= r_neg5;
        r_quo6  <= r_quo5;
    end

    assign o_verdict = '{valid: r_v6, hot: r_hot6, still: r_still, neg: r_neg6, quo: r_quo6};

endmodule

// File: rtl/core/gsbc_decide.sv
module gsbc_decide
    import gsbc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_verdict                i_verdict,
    input  logic [LIMIT_CFG_W-1:0]  i_still_limit,
    output logic                    o_push,
    output t_result                 o_result
);

    logic [COUNT_W-1:0]         r_count;
    logic                       r_done;
    logic                       r_still;
    logic [2:0][OFFSET_W-1:0]   r_bias;
    logic                       r_push;
    t_result                    r_result;

    logic [COUNT_W-1:0]         n_count;
    logic                       n_done;
    logic                       n_still;
    logic [2:0][OFFSET_W-1:0]   n_bias;

    // still counter and one-time offset latch
    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        n_still = r_still;
        n_bias  = r_bias;
        if (i_verdict.valid && i_verdict.hot && !r_done) begin
            if (i_verdict.still) begin
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_W'(1);
                end
            end else begin
                n_count = '0;
            end
            if (n_count > COUNT_W'(i_still_limit)) begin
                for (int a = 0; a < 3; a++) begin
                    n_bias[a] = sat_offset(i_verdict.quo[a], i_verdict.neg[a]);
                end
                n_still = 1'b1;
                n_done  = 1'b1;
            end else begin
                n_still = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
            r_still <= 1'b0;
            r_bias  <= '0;
            r_push  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
            r_still <= n_still;
            r_bias  <= n_bias;
            r_push  <= i_verdict.valid;
        end
        r_result <= '{still_flag: n_still, calibrated: n_done, offset: n_bias,
                      still_count: n_count};
    end

    assign o_push   = r_push;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("calibrated flag dropped");

    a_done_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_still)
        else $error("calibrated without still flag");
`endif

endmodule

// File: rtl/core/gsbc_outq.sv
module gsbc_outq
    import gsbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_data,
    input  logic        i_pop,
    output logic        o_valid,
    output t_result     o_data
);

    t_result                r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wr_ptr;
    logic [OUTQ_PTR_W-1:0]  r_rd_ptr;
    logic [CREDIT_W-1:0]    r_level;
    logic                   pop_ok;

    assign pop_ok = i_pop && (r_level != '0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUTQ_PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + OUTQ_PTR_W'(1);
            end
            r_level <= r_level + CREDIT_W'(i_push) - CREDIT_W'(pop_ok);
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// File: rtl/core/gyro_still_bias_calibrator_top.sv
// Gyro still-detect bias calibrator.
// Input channel (i_valid / o_stall): one three-axis raw gyro sample plus a raw
// temperature word per item. Output channel (o_valid / i_stall): one result item
// per input item, in order: still flag, calibrated flag, three latched offsets
// (mean counts, 4 fraction bits) and the consecutive still count.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 temperature
// threshold, 1 spread threshold, 2 mean threshold, 3 still limit; other indexes
// are ignored. Write only while no item is in flight.
// Throughput: one item per cycle while o_stall is low. The window memory is
// read for the oldest sample in the accept cycle and written in the next
// cycle, so consecutive items never touch the same entry.
// Each item passes 7 pipeline stages and the result queue before its result
// is offered.
// Reset clears the window state (the memory needs no clearing pass: entries not
// yet written on the first pass read as zero), the counters, the offsets and the
// registers to their defaults; o_stall is low out of reset.
// When the receiver stalls, results collect in a 16-entry queue; o_stall rises
// once 16 items are in flight and falls as results are taken.
module gyro_still_bias_calibrator_top
    import gsbc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [IN_W-1:0]      i_gyro_x,
    input  logic signed [IN_W-1:0]      i_gyro_y,
    input  logic signed [IN_W-1:0]      i_gyro_z,
    input  logic signed [IN_W-1:0]      i_temperature_raw,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_still_flag,
    output logic                        o_calibrated,
    output logic signed [OFFSET_W-1:0]  o_offset_x,
    output logic signed [OFFSET_W-1:0]  o_offset_y,
    output logic signed [OFFSET_W-1:0]  o_offset_z,
    output logic [COUNT_W-1:0]          o_still_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    logic signed [TEMP_W-1:0]   r_temp_thr;
    t_limits                    r_lim;
    logic [LIMIT_CFG_W-1:0]     r_still_limit;
    logic [CREDIT_W-1:0]        r_inflight;

    logic                       accept;
    logic                       pop;
    logic                       hot;
    logic [2:0][IN_W-1:0]       gyro;
    t_window_stat               stat;
    t_verdict                   verdict;
    logic                       push;
    t_result                    result;
    t_result                    head;

    // configuration registers; the stillness limits are kept pre-scaled by N and N*N
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_thr     <= TEMP_THR_RST;
            r_lim          <= '{spread_lim: SPREAD_LIM_RST, mean_lim: MEAN_LIM_RST};
            r_still_limit  <= STILL_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TEMP_THR: begin
                    r_temp_thr <= TEMP_W'(i_cfg_data);
                end
                CFG_SPREAD_THR: begin
                    r_lim.spread_lim <= SPREAD_LIM_W'(i_cfg_data[SPREAD_CFG_W-1:0])
                                      * SPREAD_LIM_W'(WINDOW_DEPTH * WINDOW_DEPTH);
                end
                CFG_MEAN_THR: begin
                    r_lim.mean_lim <= MEAN_LIM_W'(i_cfg_data[MEAN_CFG_W-1:0])
                                    * MEAN_LIM_W'(WINDOW_DEPTH);
                end
                CFG_STILL_LIMIT: begin
                    r_still_limit <= i_cfg_data[LIMIT_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input handshake with credit for every item in flight
    assign o_stall = (r_inflight == CREDIT_W'(OUTQ_DEPTH));
    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CREDIT_W'(accept) - CREDIT_W'(pop);
        end
    end

    assign hot  = (i_temperature_raw > r_temp_thr);
    assign gyro = {i_gyro_z, i_gyro_y, i_gyro_x};

    gsbc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_hot    (hot),
        .i_gyro   (gyro),
        .o_stat   (stat)
    );

    gsbc_stats u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stat    (stat),
        .i_lim     (r_lim),
        .o_verdict (verdict)
    );

    gsbc_decide u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_verdict     (verdict),
        .i_still_limit (r_still_limit),
        .o_push        (push),
        .o_result      (result)
    );

    gsbc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_data  (head)
    );

    // result fields
    assign o_still_flag  = head.still_flag;
    assign o_calibrated  = head.calibrated;
    assign o_offset_x    = $signed(head.offset[0]);
    assign o_offset_y    = $signed(head.offset[1]);
    assign o_offset_z    = $signed(head.offset[2]);
    assign o_still_count = head.still_count;

`ifndef SYNTHESIS
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CREDIT_W'(OUTQ_DEPTH))
        else $error("more items in flight than queue entries");

    a_valid_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_inflight != '0))
        else $error("result offered with no item in flight");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gsbc_pkg::*;

    typedef longint unsigned u64;

    localparam u64 DEPTH_N      = u64'(WINDOW_DEPTH);
    localparam u64 OFF_HALF     = u64'(1) << (OFFSET_W - 1);
    localparam int STEADY_ITEMS = 100;

    // bias estimator: sliding window statistics, still detection and offset latch
    class calib_scoreboard;
        logic signed [SAMPLE_WIDTH-1:0] window [3][WINDOW_DEPTH];
        int unsigned                    slot;
        longint                         sum_acc [3];
        u64                             sq_acc [3];
        int unsigned                    run_len;
        bit                             done;
        bit                             still;
        logic signed [OFFSET_W-1:0]     bias [3];
        logic signed [15:0]             temp_thr;
        logic [15:0]                    spread_thr;
        logic [14:0]                    mean_thr;
        logic [15:0]                    limit;
        t_result                        expected [$];
        int                             checked;
        int                             errors;

        function new();
            foreach (window[a, i]) begin
                window[a][i] = '0;
            end
            for (int a = 0; a < 3; a++) begin
                sum_acc[a] = 0;
                sq_acc[a]  = 0;
                bias[a]    = '0;
            end
            slot       = 0;
            run_len    = 0;
            done       = 1'b0;
            still      = 1'b0;
            temp_thr   = 16'sd8192;
            spread_thr = 16'd17;
            mean_thr   = 15'd98;
            limit      = 16'd200;
            checked    = 0;
            errors     = 0;
        endfunction

        function u64 magnitude(longint s);
            return (s < 0) ? u64'(-s) : u64'(s);
        endfunction

        // mean in counts with 4 fraction bits, rounded half away from zero
        function logic signed [OFFSET_W-1:0] round_mean(longint s);
            u64 q;
            q = (magnitude(s) * 16 + DEPTH_N / 2) / DEPTH_N;
            if (s < 0) begin
                if (q > OFF_HALF) begin
                    q = OFF_HALF;
                end
                return OFFSET_W'(-longint'(q));
            end
            if (q > OFF_HALF - 1) begin
                q = OFF_HALF - 1;
            end
            return OFFSET_W'(q);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TEMP_THR:    temp_thr   = data;
                CFG_SPREAD_THR:  spread_thr = data;
                CFG_MEAN_THR:    mean_thr   = data[14:0];
                CFG_STILL_LIMIT: limit      = data;
                default: ;
            endcase
        endfunction

        // accepted item: slide the window, run the still test, queue the result
        function void note_sample(logic signed [15:0] gx, logic signed [15:0] gy,
                                  logic signed [15:0] gz, logic signed [15:0] tr);
            logic signed [15:0]             raw [3];
            logic signed [SAMPLE_WIDTH-1:0] v;
            logic signed [SAMPLE_WIDTH-1:0] old;
            u64                             spread;
            u64                             absmean;
            u64                             m;
            t_result                        r;
            raw[0] = gx;
            raw[1] = gy;
            raw[2] = gz;
            for (int a = 0; a < 3; a++) begin
                v   = raw[a];
                old = window[a][slot];
                window[a][slot] = v;
                sum_acc[a] += longint'(v) - longint'(old);
                sq_acc[a]  += longint'(v) * longint'(v) - longint'(old) * longint'(old);
            end
            slot = (slot + 1 == WINDOW_DEPTH) ? 0 : slot + 1;

            // stillness test only while warm and not yet calibrated
            if (tr > temp_thr && !done) begin
                spread  = 0;
                absmean = 0;
                for (int a = 0; a < 3; a++) begin
                    m = magnitude(sum_acc[a]);
                    spread  += DEPTH_N * sq_acc[a] - m * m;
                    absmean += m;
                end
                if (spread < u64'(spread_thr) * DEPTH_N * DEPTH_N &&
                    absmean < u64'(mean_thr) * DEPTH_N) begin
                    if (run_len < 32'hffff) begin
                        run_len++;
                    end
                end else begin
                    run_len = 0;
                end
                if (run_len > limit) begin
                    for (int a = 0; a < 3; a++) begin
                        bias[a] = round_mean(sum_acc[a]);
                    end
                    still = 1'b1;
                    done  = 1'b1;
                end else begin
                    still = 1'b0;
                end
            end

            r.still_flag  = still;
            r.calibrated  = done;
            r.still_count = COUNT_W'(run_len);
            for (int a = 0; a < 3; a++) begin
                r.offset[a] = bias[a];
            end
            expected.push_back(r);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        task check_result(t_result got);
            t_result want;
            string   axes;
            axes = "xyz";
            checked++;
            if (expected.size() == 0) begin
                report($sformatf("result %0d arrived with no item outstanding", checked));
                return;
            end
            want = expected.pop_front();
            if (got.still_flag !== want.still_flag) begin
                report($sformatf("result %0d still_flag: got %0b, expected %0b",
                                 checked, got.still_flag, want.still_flag));
            end
            if (got.calibrated !== want.calibrated) begin
                report($sformatf("result %0d calibrated: got %0b, expected %0b",
                                 checked, got.calibrated, want.calibrated));
            end
            for (int a = 0; a < 3; a++) begin
                if (got.offset[a] !== want.offset[a]) begin
                    report($sformatf("result %0d offset_%c: got %0d, expected %0d", checked,
                                     axes[a], $signed(got.offset[a]), $signed(want.offset[a])));
                end
            end
            if (got.still_count !== want.still_count) begin
                report($sformatf("result %0d still_count: got %0d, expected %0d",
                                 checked, got.still_count, want.still_count));
            end
        endtask

        task close_out();
            if (expected.size() != 0) begin
                report($sformatf("%0d results never arrived", expected.size()));
            end
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [IN_W-1:0]     i_gyro_x;
    logic signed [IN_W-1:0]     i_gyro_y;
    logic signed [IN_W-1:0]     i_gyro_z;
    logic signed [IN_W-1:0]     i_temperature_raw;
    logic                       o_valid;
    logic                       i_stall;
    logic                       o_still_flag;
    logic                       o_calibrated;
    logic signed [OFFSET_W-1:0] o_offset_x;
    logic signed [OFFSET_W-1:0] o_offset_y;
    logic signed [OFFSET_W-1:0] o_offset_z;
    logic [COUNT_W-1:0]         o_still_count;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    calib_scoreboard    sb;
    t_result            seen;
    logic signed [15:0] cur_temp_thr = 16'sd8192;
    int                 burst_left = 0;
    logic [7:0]         stall_pat = '0;
    int                 stall_left = 0;

    gyro_still_bias_calibrator_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_gyro_x          (i_gyro_x),
        .i_gyro_y          (i_gyro_y),
        .i_gyro_z          (i_gyro_z),
        .i_temperature_raw (i_temperature_raw),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_still_flag      (o_still_flag),
        .o_calibrated      (o_calibrated),
        .o_offset_x        (o_offset_x),
        .o_offset_y        (o_offset_y),
        .o_offset_z        (o_offset_z),
        .o_still_count     (o_still_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // receiver stall: rotating pattern, redrawn when a random countdown expires
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(20, 300);
            case ($urandom_range(0, 3))
                0:       stall_pat = '0;
                1:       stall_pat = 8'($urandom & $urandom & $urandom);
                2:       stall_pat = 8'($urandom & $urandom);
                default: stall_pat = 8'($urandom);
            endcase
        end
        stall_left--;
        stall_pat = {stall_pat[6:0], stall_pat[7]};
        i_stall <= stall_pat[0];
    end

    // observe both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_sample(i_gyro_x, i_gyro_y, i_gyro_z, i_temperature_raw);
            end
            if (o_valid && !i_stall) begin
                seen.still_flag  = o_still_flag;
                seen.calibrated  = o_calibrated;
                seen.offset[0]   = o_offset_x;
                seen.offset[1]   = o_offset_y;
                seen.offset[2]   = o_offset_z;
                seen.still_count = o_still_count;
                sb.check_result(seen);
            end
        end
    end

    // temperature above or at/below the current threshold
    function automatic logic signed [15:0] pick_temp(bit hot);
        int lo;
        int hi;
        if (hot && cur_temp_thr != 16'sh7fff) begin
            lo = cur_temp_thr + 1;
            return 16'(lo + int'($urandom_range(32767 - lo, 0)));
        end
        if (!hot) begin
            hi = cur_temp_thr;
            return 16'(-32768 + int'($urandom_range(hi + 32768, 0)));
        end
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] jitter(int b, int k);
        return 16'(b + int'($urandom_range(2 * k, 0)) - k);
    endfunction

    // one item, sent in bursts with random gaps
    task automatic push_sample(input logic signed [15:0] gx, input logic signed [15:0] gy,
                               input logic signed [15:0] gz, input logic signed [15:0] tr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid           <= 1'b1;
        i_gyro_x          <= gx;
        i_gyro_y          <= gy;
        i_gyro_z          <= gz;
        i_temperature_raw <= tr;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
    endtask

    // write every register plus one index outside the map
    task automatic apply_settings(input logic signed [15:0] temp, input logic [15:0] spread,
                                  input logic [15:0] mean_data, input logic [15:0] lim);
        write_register(CFG_TEMP_THR, temp);
        write_register(CFG_SPREAD_THR, spread);
        write_register(CFG_MEAN_THR, mean_data);
        write_register(CFG_STILL_LIMIT, lim);
        write_register(CFG_INDEX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        cur_temp_thr = temp;
    endtask

    // stop sending and wait until every result is back and the pipe is empty
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // mostly still runs around a small bias, some noise and cold stretches
    task automatic run_mix(input int n);
        int sent;
        int len;
        int kind;
        int k;
        int bx;
        int by;
        int bz;
        bit hot;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                len = $urandom_range(20, 120);
                bx  = int'($urandom_range(80, 0)) - 40;
                by  = int'($urandom_range(80, 0)) - 40;
                bz  = int'($urandom_range(80, 0)) - 40;
                k   = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) begin
                    hot = ($urandom_range(0, 15) != 0);
                    if ($urandom_range(0, 39) == 0) begin
                        push_sample(16'($urandom), 16'($urandom), 16'($urandom), pick_temp(hot));
                    end else begin
                        push_sample(jitter(bx, k), jitter(by, k), jitter(bz, k), pick_temp(hot));
                    end
                end
            end else if (kind <= 8) begin
                len = $urandom_range(1, 10);
                repeat (len) begin
                    push_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                end
            end else begin
                len = $urandom_range(5, 30);
                repeat (len) begin
                    push_sample(16'($urandom), 16'($urandom), 16'($urandom), pick_temp(1'b0));
                end
            end
            sent += len;
        end
    endtask

    // main sequence
    initial begin
        int bx;
        int by;
        int bz;
        int k;
        int lim;
        sb = new();
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_gyro_x          <= '0;
        i_gyro_y          <= '0;
        i_gyro_z          <= '0;
        i_temperature_raw <= '0;
        i_stall           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // field extremes and the temperature edge under reset settings
        push_sample(16'h7fff, 16'h8000, 16'h0000, 16'h8000);
        push_sample(16'h8000, 16'h7fff, 16'hffff, 16'sd8192);
        push_sample(16'h0000, 16'h0000, 16'h0000, 16'sd8193);
        push_sample(16'h0001, 16'hffff, 16'h5555, 16'h7fff);
        push_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h0000);
        repeat (15) begin
            push_sample(jitter(3, 1), jitter(-2, 1), jitter(0, 1), 16'h7fff);
        end

        // lowest temperature threshold, loosest limits
        settle();
        apply_settings(16'h8000, 16'hffff, 16'h7fff, 16'hffff);
        run_mix(100);

        // random thresholds near typical still statistics
        for (int p = 0; p < 4; p++) begin
            settle();
            apply_settings(16'(int'($urandom_range(4000, 0)) - 2000),
                           16'($urandom_range(0, 40)),
                           {1'($urandom_range(0, 1)), 15'($urandom_range(0, 200))},
                           16'hffff);
            run_mix(100);
        end

        // nothing is warm enough, tightest limits
        settle();
        apply_settings(16'h7fff, 16'h0000, 16'h0000, 16'hffff);
        run_mix(60);

        // constant warm input, the still count keeps climbing
        settle();
        apply_settings(16'h8000, 16'h0001, 16'h7fff, 16'hffff);
        bx = int'($urandom_range(4000, 0)) - 2000;
        by = int'($urandom_range(4000, 0)) - 2000;
        bz = int'($urandom_range(4000, 0)) - 2000;
        repeat (STEADY_ITEMS) begin
            push_sample(16'(bx), 16'(by), 16'(bz), pick_temp(1'b1));
        end

        // latch offsets: clear the count, prime the window cold, then hold still warm
        settle();
        lim = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 60);
        apply_settings(16'h0000, 16'($urandom_range(20, 60)), 16'h7fff, 16'(lim));
        bx = int'($urandom_range(4000, 0)) - 2000;
        by = int'($urandom_range(4000, 0)) - 2000;
        bz = int'($urandom_range(4000, 0)) - 2000;
        k  = $urandom_range(0, 2);
        push_sample(16'h7fff, 16'h8000, 16'h7fff, pick_temp(1'b1));
        repeat (WINDOW_DEPTH) begin
            push_sample(jitter(bx, k), jitter(by, k), jitter(bz, k), pick_temp(1'b0));
        end
        repeat (lim + 80) begin
            push_sample(jitter(bx, k), jitter(by, k), jitter(bz, k), pick_temp(1'b1));
        end

        // calibrated: the window keeps sliding, outputs stay put
        run_mix(100);

        settle();
        sb.close_out();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("ERROR: timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: gyro_still_bias_calibrator_top.f
rtl/core/gsbc_pkg.sv
rtl/core/gsbc_ram.sv
rtl/core/gsbc_window.sv
rtl/core/gsbc_stats.sv
rtl/core/gsbc_decide.sv
rtl/core/gsbc_outq.sv
rtl/core/gyro_still_bias_calibrator_top.sv
sim/testbench.sv
